@@ hdl/pfla_pkg.sv @@
// Shared types, codes and helpers of the page free list allocator.
package pfla_pkg;

   localparam int DEF_MAX_PAGES = 65536;
   localparam int DEF_PAGE_SIZE = 4096;
   localparam int CMD_DEPTH     = 2;
   localparam int RSP_DEPTH     = 2;

   typedef logic [1:0] kind_type;
   localparam kind_type KIND_ALLOC       = 2'd0;
   localparam kind_type KIND_FREE        = 2'd1;
   localparam kind_type KIND_RANGE_FIRST = 2'd2;
   localparam kind_type KIND_RANGE_ADD   = 2'd3;

   typedef logic [1:0] status_type;
   localparam status_type STATUS_OK       = 2'd0;
   localparam status_type STATUS_EMPTY    = 2'd1;
   localparam status_type STATUS_BAD      = 2'd2;
   localparam status_type STATUS_OVERFLOW = 2'd3;

   typedef logic [1:0] csr_index_type;
   localparam csr_index_type CSR_KERNEL_END  = 2'd0;
   localparam csr_index_type CSR_PHYS_TOP    = 2'd1;
   localparam csr_index_type CSR_KERNEL_BASE = 2'd2;

   localparam logic [31:0] RESET_KERNEL_END  = 32'h0000_0000;
   localparam logic [31:0] RESET_PHYS_TOP    = 32'h0E00_0000;
   localparam logic [31:0] RESET_KERNEL_BASE = 32'h8000_0000;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] address;
      logic [31:0] range_end;
   } req_word_type;

   typedef struct packed {
      logic [31:0] page_address;
      status_type  status;
      logic [16:0] free_pages;
      logic [31:0] initial_pages;
   } rsp_word_type;

   typedef struct packed {
      logic [31:0] kernel_end_address;
      logic [31:0] phys_top_address;
      logic [31:0] kernel_base_address;
   } cfg_type;

   typedef struct packed {
      req_word_type word;
      logic         free_bad;
   } cmd_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_ALLOC,
      BACK_WALK
   } back_state_type;

   // Address is outside the freeable window (alignment is checked by the caller).
   function automatic logic range_bad(input logic [31:0] addr, input cfg_type cfg);
      logic [31:0] phys;
      phys = addr - cfg.kernel_base_address;
      return (addr < cfg.kernel_end_address) || (phys >= cfg.phys_top_address);
   endfunction

endpackage

@@ hdl/pfla_front.sv @@
// Front end: accepts request words, classifies them and queues them for the back end.
module pfla_front #(
   parameter int PAGE_SIZE = pfla_pkg::DEF_PAGE_SIZE
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  pfla_pkg::req_word_type req_word,
   input  pfla_pkg::cfg_type      cfg,
   output logic                   cmd_valid,
   input  logic                   cmd_pop,
   output pfla_pkg::cmd_type      cmd
);
   import pfla_pkg::*;

   localparam int SHIFT = $clog2(PAGE_SIZE);
   localparam int PTR_W = $clog2(CMD_DEPTH);
   localparam int CNT_W = $clog2(CMD_DEPTH + 1);

   cmd_type            queue_ff [CMD_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push_ok, pop_ok;
   cmd_type            cmd_in;

   assign full      = (count_ff == CNT_W'(CMD_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign push_ok   = push && !full;
   assign pop_ok    = cmd_pop && cmd_valid;
   assign cmd       = queue_ff[rd_ptr_ff];

   // Classify: a free is judged here, against the registers as they stand.
   always_comb begin
      cmd_in.word     = req_word;
      cmd_in.free_bad = (req_word.address[SHIFT-1:0] != '0) || range_bad(req_word.address, cfg);
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         queue_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule

@@ hdl/pfla_back.sv @@
// Back end: runs each command against the free page stack memory.
module pfla_back #(
   parameter int MAX_PAGES = pfla_pkg::DEF_MAX_PAGES,
   parameter int PAGE_SIZE = pfla_pkg::DEF_PAGE_SIZE
) (
   input  logic                   clock,
   input  logic                   reset,
   input  pfla_pkg::cfg_type      cfg,
   input  logic                   cmd_valid,
   input  pfla_pkg::cmd_type      cmd,
   output logic                   cmd_pop,
   input  logic                   rsp_full,
   output logic                   rsp_push,
   output pfla_pkg::rsp_word_type rsp_word
);
   import pfla_pkg::*;

   localparam int SHIFT   = $clog2(PAGE_SIZE);
   localparam int PAGE_W  = 32 - SHIFT;
   localparam int LO_W    = PAGE_W + 1;
   localparam int DEPTH_W = $clog2(MAX_PAGES + 1);
   localparam int IDX_W   = $clog2(MAX_PAGES);

   logic [PAGE_W-1:0]  stack_mem [MAX_PAGES];
   logic [PAGE_W-1:0]  rd_data_ff;

   back_state_type     state_ff, state_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic [31:0]        initial_ff, initial_in;
   logic [LO_W-1:0]    walk_ff, walk_in;
   logic [PAGE_W-1:0]  hi_ff, hi_in;
   logic [LO_W-1:0]    count_ff, count_in;
   logic               add_ff, add_in;

   logic               mem_we, mem_re;
   logic [IDX_W-1:0]   mem_waddr, mem_raddr;
   logic [PAGE_W-1:0]  mem_wdata;

   logic               start;
   logic               stack_full;
   logic [DEPTH_W-1:0] depth_inc, depth_dec;
   logic [32:0]        lo_sum;
   logic [LO_W-1:0]    lo_n, hi_ext, range_count;
   logic [PAGE_W-1:0]  hi_n;
   logic               walk_done, walk_bad;
   logic [31:0]        walk_addr;
   logic [32:0]        initial_sum;
   logic [31:0]        initial_fin;

   assign start      = (state_ff == BACK_IDLE) && cmd_valid && !rsp_full;
   assign stack_full = (depth_ff == DEPTH_W'(MAX_PAGES));
   assign depth_inc  = depth_ff + DEPTH_W'(1);
   assign depth_dec  = depth_ff - DEPTH_W'(1);

   // Page numbers of a range: first whole page up to the end rounded down.
   assign lo_sum      = {1'b0, cmd.word.address} + 33'(PAGE_SIZE - 1);
   assign lo_n        = lo_sum[32:SHIFT];
   assign hi_n        = cmd.word.range_end[31:SHIFT];
   assign hi_ext      = {1'b0, hi_n};
   assign range_count = (hi_ext > lo_n) ? hi_ext - lo_n : '0;

   assign walk_done = (walk_ff >= {1'b0, hi_ff});
   assign walk_addr = {walk_ff[PAGE_W-1:0], {SHIFT{1'b0}}};
   assign walk_bad  = range_bad(walk_addr, cfg);

   assign initial_sum = {1'b0, initial_ff} + 33'(count_ff);
   assign initial_fin = add_ff ? (initial_sum[32] ? '1 : initial_sum[31:0]) : 32'(count_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BACK_IDLE: begin
            if (start) begin
               unique case (cmd.word.kind) inside
                  KIND_ALLOC: begin
                     if (depth_ff != '0) begin
                        state_in = BACK_ALLOC;
                     end
                  end
                  KIND_FREE: ;
                  KIND_RANGE_FIRST, KIND_RANGE_ADD: state_in = BACK_WALK;
               endcase
            end
         end
         BACK_ALLOC: state_in = BACK_IDLE;
         BACK_WALK: begin
            if (walk_done || walk_bad || stack_full) begin
               state_in = BACK_IDLE;
            end
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   always_comb begin
      cmd_pop               = 1'b0;
      rsp_push              = 1'b0;
      rsp_word.page_address = '0;
      rsp_word.status       = STATUS_OK;
      mem_we                = 1'b0;
      mem_re                = 1'b0;
      mem_waddr             = depth_ff[IDX_W-1:0];
      mem_raddr             = depth_dec[IDX_W-1:0];
      mem_wdata             = cmd.word.address[31:SHIFT];
      depth_in              = depth_ff;
      initial_in            = initial_ff;
      walk_in               = walk_ff;
      hi_in                 = hi_ff;
      count_in              = count_ff;
      add_in                = add_ff;
      unique case (state_ff)
         BACK_IDLE: begin
            if (start) begin
               cmd_pop = 1'b1;
               unique case (cmd.word.kind) inside
                  KIND_ALLOC: begin
                     if (depth_ff == '0) begin
                        rsp_push        = 1'b1;
                        rsp_word.status = STATUS_EMPTY;
                     end else begin
                        depth_in = depth_dec;
                        mem_re   = 1'b1;
                     end
                  end
                  KIND_FREE: begin
                     rsp_push = 1'b1;
                     if (cmd.free_bad) begin
                        rsp_word.status = STATUS_BAD;
                     end else if (stack_full) begin
                        rsp_word.status = STATUS_OVERFLOW;
                     end else begin
                        mem_we   = 1'b1;
                        depth_in = depth_inc;
                     end
                  end
                  KIND_RANGE_FIRST, KIND_RANGE_ADD: begin
                     walk_in  = lo_n;
                     hi_in    = hi_n;
                     count_in = range_count;
                     add_in   = (cmd.word.kind == KIND_RANGE_ADD);
                  end
               endcase
            end
         end
         BACK_ALLOC: begin
            rsp_push              = 1'b1;
            rsp_word.page_address = {rd_data_ff, {SHIFT{1'b0}}};
         end
         BACK_WALK: begin
            if (walk_done || walk_bad || stack_full) begin
               rsp_push   = 1'b1;
               initial_in = initial_fin;
               if (walk_done) begin
                  rsp_word.status = STATUS_OK;
               end else if (walk_bad) begin
                  rsp_word.status = STATUS_BAD;
               end else begin
                  rsp_word.status = STATUS_OVERFLOW;
               end
            end else begin
               mem_we    = 1'b1;
               mem_wdata = walk_ff[PAGE_W-1:0];
               depth_in  = depth_inc;
               walk_in   = walk_ff + LO_W'(1);
            end
         end
         default: ;
      endcase
      rsp_word.free_pages    = 17'(depth_in);
      rsp_word.initial_pages = initial_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= BACK_IDLE;
         depth_ff   <= '0;
         initial_ff <= '0;
      end else begin
         state_ff   <= state_in;
         depth_ff   <= depth_in;
         initial_ff <= initial_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_ff  <= walk_in;
      hi_ff    <= hi_in;
      count_ff <= count_in;
      add_ff   <= add_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= stack_mem[mem_raddr];
      end
   end

`ifndef SYNTHESIS
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DEPTH_W'(MAX_PAGES))
      else $error("stack depth above capacity");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full)
      else $error("result written into a full queue");

   a_alloc_popped: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BACK_ALLOC) |-> ($past(depth_ff) == depth_ff + DEPTH_W'(1)))
      else $error("alloc read without a stack pop");

   a_walk_push: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BACK_WALK && mem_we) |=> (depth_ff == $past(depth_ff) + DEPTH_W'(1)))
      else $error("range page written without a depth step");
`endif

endmodule

@@ hdl/pfla_rsp_queue.sv @@
// Result queue between the back end and the result ports.
module pfla_rsp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_push,
   output logic                   wr_full,
   input  pfla_pkg::rsp_word_type wr_word,
   output logic                   empty,
   input  logic                   pop,
   output pfla_pkg::rsp_word_type rsp_word
);
   import pfla_pkg::*;

   localparam int PTR_W = $clog2(RSP_DEPTH);
   localparam int CNT_W = $clog2(RSP_DEPTH + 1);

   rsp_word_type     queue_ff [RSP_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push_ok, pop_ok;

   assign wr_full  = (count_ff == CNT_W'(RSP_DEPTH));
   assign empty    = (count_ff == '0);
   assign push_ok  = wr_push && !wr_full;
   assign pop_ok   = pop && !empty;
   assign rsp_word = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(RSP_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(RSP_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         queue_ff[wr_ptr_ff] <= wr_word;
      end
   end

endmodule

@@ hdl/page_free_list_allocator_top.sv @@
// Top level of the page free list allocator: registers, front end, back end, result queue.
// A result passes the command queue, the back end and the result queue before it is visible.
// Throughput is set by the back end sequencer and its stack memory: one free per cycle while
// the result queue has room; an alloc holds it in a read state; a range pushes one page a cycle.
// Synchronous reset empties the stack, zeroes the initial page count, drains both queues
// and loads the register reset values; the stack memory itself is not cleared.
module page_free_list_allocator_top #(
   parameter int MAX_PAGES = pfla_pkg::DEF_MAX_PAGES,
   parameter int PAGE_SIZE = pfla_pkg::DEF_PAGE_SIZE
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   output logic                    full,
   input  pfla_pkg::req_word_type  req_word,
   output logic                    empty,
   input  logic                    pop,
   output pfla_pkg::rsp_word_type  rsp_word,
   input  logic                    csr_write_enable,
   input  pfla_pkg::csr_index_type csr_index,
   input  logic [31:0]             csr_write_data
);
   import pfla_pkg::*;

   // Configuration registers: to be written only while the block is idle; the block does not enforce it.
   logic [31:0]  kernel_end_ff, kernel_end_in;
   logic [31:0]  phys_top_ff, phys_top_in;
   logic [31:0]  kernel_base_ff, kernel_base_in;
   cfg_type      cfg;

   // Front to back command queue.
   logic         cmd_valid;
   logic         cmd_pop;
   cmd_type      cmd;

   // Back end to result queue.
   logic         rsp_push;
   logic         rsp_full;
   rsp_word_type rsp_word_in;

   assign cfg.kernel_end_address  = kernel_end_ff;
   assign cfg.phys_top_address    = phys_top_ff;
   assign cfg.kernel_base_address = kernel_base_ff;

   // Decode a register write; an index past the list is dropped.
   always_comb begin
      kernel_end_in  = kernel_end_ff;
      phys_top_in    = phys_top_ff;
      kernel_base_in = kernel_base_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_KERNEL_END:  kernel_end_in  = csr_write_data;
            CSR_PHYS_TOP:    phys_top_in    = csr_write_data;
            CSR_KERNEL_BASE: kernel_base_in = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_end_ff  <= RESET_KERNEL_END;
         phys_top_ff    <= RESET_PHYS_TOP;
         kernel_base_ff <= RESET_KERNEL_BASE;
      end else begin
         kernel_end_ff  <= kernel_end_in;
         phys_top_ff    <= phys_top_in;
         kernel_base_ff <= kernel_base_in;
      end
   end

   // Accept and classify request words; hold them until the back end is free.
   pfla_front #(
      .PAGE_SIZE (PAGE_SIZE)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_word  (req_word),
      .cfg       (cfg),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd       (cmd)
   );

   // Carry out each command on the stack; start one only when the result has room.
   pfla_back #(
      .MAX_PAGES (MAX_PAGES),
      .PAGE_SIZE (PAGE_SIZE)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_word  (rsp_word_in)
   );

   // Hold finished results until popped, so the back end keeps working meanwhile.
   pfla_rsp_queue u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_push  (rsp_push),
      .wr_full  (rsp_full),
      .wr_word  (rsp_word_in),
      .empty    (empty),
      .pop      (pop),
      .rsp_word (rsp_word)
   );

endmodule

@@ verif/page_free_list_allocator_top_tb.sv @@
// Self-checking testbench of the page free list allocator: queued stimulus, scoreboard, idling.
module page_free_list_allocator_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pfla_pkg::*;

   localparam int          CLOCK_PERIOD = 10;
   localparam int          CYCLE_LIMIT  = 2_000_000;
   localparam int          MAX_PAGES    = DEF_MAX_PAGES;
   localparam logic [31:0] PAGE_BYTES   = 32'(DEF_PAGE_SIZE);
   localparam logic [63:0] PAGE_WIDE    = 64'(DEF_PAGE_SIZE);

   // Clock, reset and every input of the block start at a known value.
   logic          clock            = 1'b0;
   logic          reset            = 1'b1;
   logic          push             = 1'b0;
   logic          full;
   req_word_type  req_word         = '0;
   logic          empty;
   logic          pop              = 1'b0;
   rsp_word_type  rsp_word;
   logic          csr_write_enable = 1'b0;
   csr_index_type csr_index        = CSR_KERNEL_END;
   logic [31:0]   csr_write_data   = '0;

   // Words waiting to be offered, and replies expected back in order.
   req_word_type  request_queue[$];
   rsp_word_type  reply_queue[$];

   // Idling percentages and the receiver hold-off, set from the stimulus process.
   int            sender_idle_pct    = 0;
   int            receiver_stall_pct = 0;
   int            pop_hold_left      = 0;

   int            fail_count  = 0;
   int            cycle_count = 0;

   // Own copy of the allocator: free page stack, depth, initial count, registers.
   logic [19:0]   page_stack[MAX_PAGES];
   int            stack_depth = 0;
   logic [31:0]   init_count  = '0;
   cfg_type       model_cfg   = '{kernel_end_address:  RESET_KERNEL_END,
                                  phys_top_address:    RESET_PHYS_TOP,
                                  kernel_base_address: RESET_KERNEL_BASE};

   page_free_list_allocator_top uut (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_word         (req_word),
      .empty            (empty),
      .pop              (pop),
      .rsp_word         (rsp_word),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // ------------------------------------------------------------------
   // Allocator behaviour
   // ------------------------------------------------------------------

   // A page may not be freed when misaligned, below the kernel end, or when its
   // physical address (modulo 2^32) lies at or above the top of memory.
   function automatic logic page_rejected(input logic [31:0] addr);
      logic [31:0] phys;
      phys = addr - model_cfg.kernel_base_address;
      return ((addr % PAGE_BYTES) != 0) || (addr < model_cfg.kernel_end_address) ||
             (phys >= model_cfg.phys_top_address);
   endfunction

   function automatic status_type push_free_page(input logic [31:0] addr);
      if (page_rejected(addr))
         return STATUS_BAD;
      if (stack_depth >= MAX_PAGES)
         return STATUS_OVERFLOW;
      page_stack[stack_depth] = 20'(addr / PAGE_BYTES);
      stack_depth++;
      return STATUS_OK;
   endfunction

   // Free every whole page of [start, stop), lowest first, in 64-bit arithmetic so
   // that a start rounding up past the top of the address space frees nothing.
   function automatic status_type walk_range(input logic [31:0] start, input logic [31:0] stop,
                                             input logic accumulate);
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] pages;
      logic [63:0] sum;
      logic [63:0] p;
      status_type  st;
      lo = (({32'd0, start} + PAGE_WIDE - 64'd1) / PAGE_WIDE) * PAGE_WIDE;
      hi = ({32'd0, stop} / PAGE_WIDE) * PAGE_WIDE;
      pages = (hi > lo) ? (hi - lo) / PAGE_WIDE : 64'd0;
      st = STATUS_OK;
      for (p = lo; p + PAGE_WIDE <= {32'd0, stop}; p += PAGE_WIDE) begin
         st = push_free_page(p[31:0]);
         if (st != STATUS_OK)
            break;
      end
      // The count is applied whether or not the walk stopped early.
      sum = accumulate ? {32'd0, init_count} + pages : pages;
      init_count = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
      return st;
   endfunction

   // Reply of the allocator to one accepted word; advances the model state.
   function automatic rsp_word_type allocator_reply(input req_word_type w);
      rsp_word_type r;
      r = '0;
      case (w.kind)
         KIND_ALLOC: begin
            if (stack_depth == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               stack_depth--;
               r.page_address = 32'(page_stack[stack_depth] * PAGE_BYTES);
               r.status = STATUS_OK;
            end
         end
         KIND_FREE: begin
            r.status = push_free_page(w.address);
         end
         default: begin
            r.status = walk_range(w.address, w.range_end, w.kind == KIND_RANGE_ADD);
         end
      endcase
      r.free_pages = 17'(stack_depth);
      r.initial_pages = init_count;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Driver: offer queued words, hold each until accepted
   // ------------------------------------------------------------------
   always @(posedge clock) begin : drive_requests
      logic taken;
      if (reset) begin
         push <= 1'b0;
      end else begin
         taken = push && !full;
         // Predict at the edge of acceptance so the order matches the block's.
         if (taken)
            reply_queue.push_back(allocator_reply(req_word));
         if (!push || taken) begin
            if (request_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               push <= 1'b1;
               req_word <= request_queue.pop_front();
            end else begin
               push <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: check each popped word against the oldest expectation
   // ------------------------------------------------------------------
   always @(posedge clock) begin : check_replies
      rsp_word_type want;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (reply_queue.size() == 0) begin
               $error("reply word with nothing expected: %h", rsp_word);
               fail_count++;
            end else begin
               want = reply_queue.pop_front();
               if (rsp_word.page_address !== want.page_address) begin
                  $error("page_address: expected %h, got %h",
                         want.page_address, rsp_word.page_address);
                  fail_count++;
               end
               if (rsp_word.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_word.status);
                  fail_count++;
               end
               if (rsp_word.free_pages !== want.free_pages) begin
                  $error("free_pages: expected %0d, got %0d",
                         want.free_pages, rsp_word.free_pages);
                  fail_count++;
               end
               if (rsp_word.initial_pages !== want.initial_pages) begin
                  $error("initial_pages: expected %0d, got %0d",
                         want.initial_pages, rsp_word.initial_pages);
                  fail_count++;
               end
            end
         end
         // A long hold-off lets the block fill up and push back on the sender.
         if (pop_hold_left > 0) begin
            pop_hold_left--;
            pop <= 1'b0;
         end else begin
            pop <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   // Drop the run if it hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   function automatic void queue_word(input kind_type k, input logic [31:0] addr,
                                      input logic [31:0] stop);
      req_word_type w;
      w.kind = k;
      w.address = addr;
      w.range_end = stop;
      request_queue.push_back(w);
   endfunction

   // Aligned page inside the physical window of the current settings; it may
   // still sit below the kernel end, which is wanted.
   function automatic logic [31:0] window_page();
      logic [31:0] last_page;
      if (model_cfg.phys_top_address < PAGE_BYTES)
         return $urandom & ~(PAGE_BYTES - 32'd1);
      last_page = (model_cfg.phys_top_address - 32'd1) / PAGE_BYTES;
      return model_cfg.kernel_base_address + 32'($urandom_range(last_page, 0)) * PAGE_BYTES;
   endfunction

   // Pages a range walk would push before its first rejected page, capped.
   function automatic int walked_pages(input logic [31:0] start, input logic [31:0] stop,
                                       input int cap);
      logic [63:0] p;
      int          n;
      n = 0;
      p = (({32'd0, start} + PAGE_WIDE - 64'd1) / PAGE_WIDE) * PAGE_WIDE;
      while (p + PAGE_WIDE <= {32'd0, stop} && n < cap && !page_rejected(p[31:0])) begin
         n++;
         p += PAGE_WIDE;
      end
      return n;
   endfunction

   // Mostly well-formed traffic against the current window, with alloc bursts to
   // drain the stack back to empty now and then, plus raw noise.
   task automatic queue_random(input int count);
      int          left;
      int          roll;
      int          burst;
      int          tries;
      int          pages;
      logic [31:0] addr;
      logic [31:0] stop;
      kind_type    range_kind;
      left = count;
      while (left > 0) begin
         roll = $urandom_range(99);
         range_kind = $urandom_range(1) ? KIND_RANGE_ADD : KIND_RANGE_FIRST;
         if (roll < 5) begin
            burst = $urandom_range(30, 8);
            repeat (burst) queue_word(KIND_ALLOC, $urandom, $urandom);
            left -= burst;
         end else if (roll < 35) begin
            queue_word(KIND_ALLOC, $urandom, $urandom);
            left--;
         end else if (roll < 65) begin
            roll = $urandom_range(99);
            if (roll < 60)
               addr = window_page();
            else if (roll < 75)
               addr = window_page() + 32'($urandom_range(PAGE_BYTES - 1, 1));
            else
               addr = $urandom;
            queue_word(KIND_FREE, addr, $urandom);
            left--;
         end else if (roll < 90) begin
            addr = window_page();
            if ($urandom_range(3) == 0)
               addr -= 32'($urandom_range(PAGE_BYTES - 1, 1));
            pages = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(4, 0);
            stop = addr + 32'(pages) * PAGE_BYTES;
            if ($urandom_range(1) != 0)
               stop += 32'($urandom_range(PAGE_BYTES - 1, 0));
            queue_word(range_kind, addr, stop);
            left--;
         end else begin
            // Raw range; keep the walk short so the run stays bounded.
            tries = 0;
            do begin
               addr = $urandom;
               stop = $urandom;
               tries++;
            end while (walked_pages(addr, stop, 65) > 64 && tries < 20);
            if (tries >= 20 && walked_pages(addr, stop, 65) > 64)
               stop = addr;
            queue_word(range_kind, addr, stop);
            left--;
         end
      end
   endtask

   task automatic set_idling(input int send_pct, input int recv_pct);
      @(negedge clock);
      sender_idle_pct = send_pct;
      receiver_stall_pct = recv_pct;
   endtask

   task automatic wait_sent();
      do @(negedge clock); while (request_queue.size() != 0);
   endtask

   // Hold off until every word is accepted and every reply has come back.
   task automatic wait_idle();
      do @(negedge clock);
      while (request_queue.size() != 0 || push || reply_queue.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [31:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      case (idx)
         CSR_KERNEL_END:  model_cfg.kernel_end_address = data;
         CSR_PHYS_TOP:    model_cfg.phys_top_address = data;
         default:         model_cfg.kernel_base_address = data;
      endcase
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic configure(input logic [31:0] kernel_end, input logic [31:0] phys_top,
                            input logic [31:0] kernel_base);
      wait_idle();
      write_csr(CSR_KERNEL_END, kernel_end);
      write_csr(CSR_PHYS_TOP, phys_top);
      write_csr(CSR_KERNEL_BASE, kernel_base);
   endtask

   // One chunk of random words under each idling pattern in turn.
   task automatic random_phase(input int count);
      set_idling(0, 0);
      queue_random(count / 4);
      wait_sent();
      set_idling(61, 0);
      queue_random(count / 4);
      wait_sent();
      set_idling(0, 61);
      queue_random(count / 4);
      wait_sent();
      set_idling(17, 17);
      queue_random(count / 4);
      wait_sent();
   endtask

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed words under the reset settings: window 0x80000000..0x8DFFFFFF.
      queue_word(KIND_ALLOC, 32'h0000_0000, 32'h0000_0000);        // empty stack
      queue_word(KIND_FREE, 32'h8000_0000, 32'hFFFF_FFFF);         // lowest good page
      queue_word(KIND_FREE, 32'h8DFF_F000, 32'h0000_0000);         // highest good page
      queue_word(KIND_FREE, 32'h8E00_0000, 32'h0000_0000);         // at top of memory
      queue_word(KIND_FREE, 32'h8000_0001, 32'h0000_0000);         // misaligned
      queue_word(KIND_FREE, 32'h7FFF_F000, 32'h0000_0000);         // physical wraps round
      queue_word(KIND_FREE, 32'hFFFF_FFFF, 32'h0000_0000);
      queue_word(KIND_FREE, 32'h0000_0000, 32'h0000_0000);
      queue_word(KIND_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);        // last in, first out
      queue_word(KIND_ALLOC, 32'h0000_0000, 32'h0000_0000);
      queue_word(KIND_ALLOC, 32'h0000_0000, 32'h0000_0000);        // empty again
      queue_word(KIND_RANGE_FIRST, 32'h8000_0001, 32'h8000_4000);  // start rounds up
      queue_word(KIND_RANGE_ADD, 32'h8001_0000, 32'h8001_0FFF);    // no whole page
      queue_word(KIND_RANGE_ADD, 32'h8002_0000, 32'h8001_0000);    // end below start
      queue_word(KIND_RANGE_FIRST, 32'hFFFF_F001, 32'hFFFF_FFFF);  // rounds past the top
      queue_word(KIND_RANGE_FIRST, 32'h8DFF_E000, 32'h8E00_2000);  // stops at a bad page
      queue_word(KIND_RANGE_ADD, 32'h0000_0000, 32'hFFFF_FFFF);    // huge count, bad start
      queue_word(KIND_RANGE_ADD, 32'hFFFF_F000, 32'hFFFF_FFFF);
      queue_word(KIND_RANGE_FIRST, 32'h0000_0000, 32'h0000_0000);
      repeat (7) queue_word(KIND_ALLOC, 32'h0000_0000, 32'h0000_0000);
      wait_idle();

      // Receiver holds off while the sender keeps offering; then the sender pauses.
      set_idling(0, 0);
      @(negedge clock);
      pop_hold_left = 300;
      queue_random(100);
      wait_idle();
      random_phase(240);

      // Narrow window with the kernel end inside it.
      configure(32'h8040_0000, 32'h0080_0000, 32'h8000_0000);
      random_phase(240);

      // Widest window: every aligned address is good.
      configure(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
      random_phase(240);

      // Base near the top so physical addresses wrap round.
      configure(32'h0000_1000, 32'h0001_0000, 32'hFFFF_F000);
      random_phase(240);

      // Nothing can be freed; push the initial count well up with large ranges.
      configure(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
      random_phase(120);
      set_idling(17, 17);
      repeat (60)
         queue_word(KIND_RANGE_ADD, 32'($urandom_range(PAGE_BYTES - 1, 0)),
                    32'($urandom_range(32'hFFFF_FFFF, 32'hFFFF_F000)));
      wait_sent();

      // Fill the stack to the brim and exercise the overflow paths.
      configure(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
      set_idling(0, 0);
      queue_word(KIND_RANGE_FIRST, 32'h0000_0000, 32'h1000_1000);
      queue_word(KIND_FREE, 32'h0000_1000, 32'h0000_0000);
      queue_word(KIND_ALLOC, 32'h0000_0000, 32'h0000_0000);
      queue_word(KIND_FREE, 32'h0000_2000, 32'h0000_0000);
      queue_word(KIND_FREE, 32'h0000_3000, 32'h0000_0000);
      queue_word(KIND_RANGE_ADD, 32'h0000_5000, 32'h0000_7000);
      repeat (3) queue_word(KIND_ALLOC, 32'h0000_0000, 32'h0000_0000);

      // Drain, then let the pipeline settle before judging.
      wait_idle();
      repeat (10) @(posedge clock);
      if (fail_count == 0 && reply_queue.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
